>>> sv/node_pair_index_mapper_assert.svh
// Assertion macros for the node pair index mapper.
// Each macro expects clk and rst_n in scope where it is used.
`ifndef NODE_PAIR_INDEX_MAPPER_ASSERT_SVH
`define NODE_PAIR_INDEX_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define NPIM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define NPIM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPIM_ASSERT(lbl, prop, msg)
`define NPIM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/npim_pkg.sv
package npim_pkg;

    localparam int NPIM_MAX_NODES = 4096;

    // Configuration register indexes
    localparam logic [7:0] REG_DIRECTED_MODE = 8'd0;
    localparam logic [7:0] REG_SELF_LOOPS    = 8'd1;
    localparam logic [7:0] REG_NODE_COUNT    = 8'd2;

    // Request commands
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Number of digit steps shared by the square root and the divider
    localparam int STEPS = 14;

    // One pipeline slot; working fields are reused from stage to stage
    typedef struct packed {
        logic        valid;
        logic        cmd;
        logic        dir;
        logic        sl;
        logic [11:0] row;
        logic [11:0] col;
        logic [23:0] v;
        logic [12:0] n;
        logic        bad;
        logic [26:0] prod;
        logic [27:0] x;
        logic [16:0] rem;
        logic [13:0] acc;
        logic [23:0] idx;
    } npim_stage_t;

endpackage

>>> sv/node_pair_index_mapper.sv
// Node pair index mapper.
// Input stream s_*: s_tuser is the command (encode or decode), s_tdata carries
// row, col and index. Output stream m_*: m_tdata carries index_out, row_out
// and col_out, m_tuser the bad_request flag. Each request gives one result.
// Configuration is written on cfg_* (always ready); the user must write it only
// while no request is in flight, which the block does not enforce. Register 0
// is directed_mode, 1 self_loops, 2 node_count. Throughput: one request per
// cycle when the pipeline is not stalled; the depth is set by the 14 digit
// steps of the square root / divider chain plus the capture, multiply, check
// and two finishing stages (19 stages in all), passed in order.
// Each stage advances when the one after it is empty or moving, so bubbles
// are squeezed out and s_tready stays high while any stage is free.
// When m_tready is low the output holds and the pipeline fills up behind it;
// s_tready drops only when all stages are full.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the registers
// to undirected, no self-loops, 4096 nodes.
`include "node_pair_index_mapper_assert.svh"

module node_pair_index_mapper
    import npim_pkg::*;
#(
    parameter int MAX_NODES = NPIM_MAX_NODES
)
(
    input  logic        clk,
    input  logic        rst_n,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row[11:0], col[23:12], index[47:24]
    input  logic        s_tuser,   // cmd[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // index_out[23:0], row_out[35:24], col_out[47:36]
    output logic        m_tuser    // bad_request[0]
);

    localparam int NS      = STEPS + 5;
    localparam int S_MUL   = 1;
    localparam int S_CHK   = 2;
    localparam int S_STEP0 = 3;
    localparam int S_FIN1  = S_STEP0 + STEPS;
    localparam int S_FIN2  = S_FIN1 + 1;

    logic        directed_reg;
    logic        self_loops_reg;
    logic [12:0] node_count_reg;
    logic [12:0] n_eff;

    npim_stage_t st_reg  [NS];
    npim_stage_t st_next [NS];
    logic [NS-1:0] adv;

    // One shared digit step: square root for undirected, division for directed
    function automatic npim_stage_t step_f(input npim_stage_t s);
        npim_stage_t o;
        logic [16:0] r2;
        logic [16:0] trial;
        logic [13:0] d2;
        o = s;
        if (s.cmd == CMD_DECODE) begin
            if (!s.dir) begin
                r2    = {s.rem[14:0], s.x[27:26]};
                trial = {1'b0, s.acc, 2'b01};
                if (r2 >= trial) begin
                    o.rem = r2 - trial;
                    o.acc = {s.acc[12:0], 1'b1};
                end
                else begin
                    o.rem = r2;
                    o.acc = {s.acc[12:0], 1'b0};
                end
                o.x = {s.x[25:0], 2'b00};
            end
            else begin
                d2 = {s.rem[12:0], s.x[27]};
                if (d2 >= {1'b0, s.n}) begin
                    o.rem = {3'b0, d2 - {1'b0, s.n}};
                    o.acc = {s.acc[12:0], 1'b1};
                end
                else begin
                    o.rem = {3'b0, d2};
                    o.acc = {s.acc[12:0], 1'b0};
                end
                o.x = {s.x[26:0], 1'b0};
            end
        end
        return o;
    endfunction

    // Clamp node count to [2, MAX_NODES]
    always_comb
    begin
        if (node_count_reg < 13'd2)
            n_eff = 13'd2;
        else if ({19'b0, node_count_reg} > MAX_NODES)
            n_eff = 13'(MAX_NODES);
        else
            n_eff = node_count_reg;
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            directed_reg   <= 1'b0;
            self_loops_reg <= 1'b0;
            node_count_reg <= 13'd4096;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DIRECTED_MODE: directed_reg   <= cfg_data[0];
                REG_SELF_LOOPS:    self_loops_reg <= cfg_data[0];
                REG_NODE_COUNT:    node_count_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Capture the request with the current mode
    always_comb
    begin
        st_next[0]       = '0;
        st_next[0].valid = s_tvalid;
        st_next[0].cmd   = s_tuser;
        st_next[0].dir   = directed_reg;
        st_next[0].sl    = self_loops_reg;
        st_next[0].row   = s_tdata[11:0];
        st_next[0].col   = s_tdata[23:12];
        st_next[0].v     = s_tdata[47:24];
        st_next[0].n     = n_eff;
    end

    // Multiply: pair base for encode, pair count for decode
    always_comb
    begin
        npim_stage_t s;
        logic [12:0] ma;
        logic [13:0] mb;
        logic [12:0] nm1;
        s   = st_reg[S_MUL-1];
        nm1 = s.n - 13'd1;
        if (s.cmd == CMD_DECODE) begin
            ma = s.n;
            if (s.dir)
                mb = s.sl ? {1'b0, s.n} : {1'b0, nm1};
            else
                mb = s.sl ? ({1'b0, s.n} + 14'd1) : {1'b0, nm1};
        end
        else begin
            ma = {1'b0, s.row};
            if (s.dir)
                mb = s.sl ? {1'b0, s.n} : {1'b0, nm1};
            else
                mb = s.sl ? ({2'b0, s.row} + 14'd1) : ({2'b0, s.row} - 14'd1);
        end
        st_next[S_MUL]      = s;
        st_next[S_MUL].prod = {14'b0, ma} * {13'b0, mb};
    end

    // Check range, finish encode, load the digit-step operands for decode
    always_comb
    begin
        npim_stage_t s;
        npim_stage_t o;
        logic [27:0] base;
        logic [27:0] sum;
        logic        corr;
        logic        bad;
        s    = st_reg[S_CHK-1];
        o    = s;
        bad  = 1'b0;
        base = s.dir ? {1'b0, s.prod} : {2'b0, s.prod[26:1]};
        corr = s.dir && !s.sl && (s.col > s.row);
        sum  = base + {16'b0, s.col} - {27'b0, corr};
        o.rem = '0;
        o.acc = '0;
        o.x   = '0;
        o.idx = '0;
        if (s.cmd == CMD_ENCODE) begin
            bad = ({1'b0, s.row} >= s.n) || ({1'b0, s.col} >= s.n);
            if (!s.dir)
                bad = bad || (s.col > s.row) || (!s.sl && (s.col == s.row));
            else
                bad = bad || (!s.sl && (s.col == s.row));
            bad   = bad || (sum > 28'hFFFFFF);
            o.bad = bad;
            o.idx = bad ? 24'd0 : sum[23:0];
        end
        else begin
            o.bad = ({4'b0, s.v} >= base);
            if (!s.dir) begin
                o.x = {1'b0, s.v, 3'b001};
            end
            else begin
                o.n   = s.sl ? s.n : (s.n - 13'd1);
                o.rem = {7'b0, s.v[23:14]};
                o.x   = {s.v[13:0], 14'b0};
            end
        end
        st_next[S_CHK] = o;
    end

    // Digit steps
    genvar g;
    generate
        for (g = S_STEP0; g < S_FIN1; g++)
        begin : g_step
            assign st_next[g] = step_f(st_reg[g-1]);
        end
    endgenerate

    // Undirected decode: triangular base of the root's row
    always_comb
    begin
        npim_stage_t s;
        logic [12:0] t;
        s = st_reg[S_FIN1-1];
        t = 13'((s.acc - 14'd1) >> 1);
        st_next[S_FIN1] = s;
        if (s.cmd == CMD_DECODE && !s.dir) begin
            st_next[S_FIN1].acc  = {1'b0, t};
            st_next[S_FIN1].prod = {14'b0, t} * ({14'b0, t} + 27'd1);
        end
    end

    // Form row and col, check their width, clear fields of bad requests
    always_comb
    begin
        npim_stage_t s;
        npim_stage_t o;
        logic [25:0] cf;
        logic [14:0] rf;
        logic        bad;
        s   = st_reg[S_FIN2-1];
        o   = s;
        cf  = '0;
        rf  = '0;
        bad = s.bad;
        if (s.cmd == CMD_DECODE) begin
            if (!s.dir) begin
                cf = {2'b0, s.v} - {s.prod[26:1]};
                rf = s.sl ? {1'b0, s.acc} : ({1'b0, s.acc} + 15'd1);
            end
            else begin
                rf = {1'b0, s.acc};
                cf = {9'b0, s.rem} +
                     {25'b0, (!s.sl && (s.rem >= {3'b0, s.acc}))};
            end
            bad   = s.bad || (rf > 15'd4095) || (cf > 26'd4095);
            o.bad = bad;
            o.row = bad ? 12'd0 : rf[11:0];
            o.col = bad ? 12'd0 : cf[11:0];
            o.idx = '0;
        end
        else begin
            o.row = '0;
            o.col = '0;
        end
        st_next[S_FIN2] = o;
    end

    // Advance a stage when it is empty or the next one moves
    assign adv[NS-1] = !st_reg[NS-1].valid || m_tready;
    generate
        for (g = 0; g < NS-1; g++)
        begin : g_adv
            assign adv[g] = !st_reg[g].valid || adv[g+1];
        end
    endgenerate

    // Pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                st_reg[k].valid <= 1'b0;
        end
        else
        begin
            st_reg[0] <= adv[0] ? st_next[0] : st_reg[0];
            for (int k = 1; k < NS; k++)
                if (adv[k])
                    st_reg[k] <= st_next[k];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = st_reg[NS-1].valid;
    assign m_tdata  = {st_reg[NS-1].col, st_reg[NS-1].row, st_reg[NS-1].idx};
    assign m_tuser  = st_reg[NS-1].bad;

    `NPIM_ASSERT(a_bad_zero, (m_tvalid && m_tuser) |-> (m_tdata == 48'd0),
                 "bad request result carries nonzero fields")
    `NPIM_ASSERT(a_enc_no_pair,
                 (m_tvalid && st_reg[NS-1].cmd == CMD_ENCODE) |-> (m_tdata[47:24] == 24'd0),
                 "encode result carries a row or col")
    `NPIM_ASSERT(a_dec_no_idx,
                 (m_tvalid && st_reg[NS-1].cmd == CMD_DECODE) |-> (m_tdata[23:0] == 24'd0),
                 "decode result carries an index")
    `NPIM_ASSERT(a_ready_when_out_free, !m_tvalid |-> s_tready,
                 "input stalled while the output stage is empty")
    `NPIM_ASSERT(a_rem_below_div,
                 (m_tvalid && st_reg[NS-1].cmd == CMD_DECODE && st_reg[NS-1].dir
                  && !m_tuser) |-> (st_reg[NS-1].rem < {4'b0, st_reg[NS-1].n}),
                 "division remainder not below divisor")

endmodule

>>> sim/tb_top.sv
`default_nettype none

module tb_top
    import npim_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 19;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [23:0] index_out;
        logic [11:0] row_out;
        logic [11:0] col_out;
        logic        bad_request;
    } pair_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    // mirrored configuration
    logic        dir_q;
    logic        sl_q;
    logic [12:0] nodes_q;

    pair_result_t expected_q[$];
    int           fail_cnt;
    int           idle_cycles;
    int           hold_req;

    node_pair_index_mapper u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // floor square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // compute the mapping result for one request
    function automatic pair_result_t map_pair(input logic cmd, input logic [11:0] row,
                                              input logic [11:0] col, input logic [23:0] vin);
        pair_result_t    res;
        longint unsigned n, r, c, v, idx, ro, co, total, t;
        bit              bad;
        n = 64'(nodes_q);
        if (n < 2) n = 64'd2;
        if (n > NPIM_MAX_NODES) n = 64'(NPIM_MAX_NODES);
        r = 64'(row); c = 64'(col); v = 64'(vin);
        bad = 0; idx = 0; ro = 0; co = 0;
        if (cmd == CMD_ENCODE)
        begin
            if (r >= n || c >= n)
                bad = 1;
            else if (!dir_q)
            begin
                if (c > r || (!sl_q && c == r)) bad = 1;
                else if (sl_q) idx = r * (r + 1) / 2 + c;
                else idx = r * (r - 1) / 2 + c;
            end
            else
            begin
                if (sl_q) idx = r * n + c;
                else if (r == c) bad = 1;
                else idx = r * (n - 1) + c - ((c > r) ? 64'd1 : 64'd0);
            end
            if (!bad && idx > 64'hFFFFFF) bad = 1;
            if (bad) idx = 0;
        end
        else
        begin
            if (!dir_q) total = sl_q ? n * (n + 1) / 2 : n * (n - 1) / 2;
            else total = sl_q ? n * n : n * (n - 1);
            if (v >= total)
                bad = 1;
            else if (!dir_q)
            begin
                t = (int_sqrt(64'd8 * v + 64'd1) - 64'd1) / 64'd2;
                if (sl_q)
                begin
                    ro = t;
                    co = v - t * (t + 1) / 2;
                end
                else
                begin
                    ro = t + 1;
                    co = v - ro * (ro - 1) / 2;
                end
            end
            else if (sl_q)
            begin
                ro = v / n;
                co = v % n;
            end
            else
            begin
                ro = v / (n - 1);
                co = v % (n - 1);
                if (co >= ro) co = co + 1;
            end
            if (!bad && (ro > 64'hFFF || co > 64'hFFF)) bad = 1;
            if (bad)
            begin
                ro = 0;
                co = 0;
            end
        end
        res.index_out   = idx[23:0];
        res.row_out     = ro[11:0];
        res.col_out     = co[11:0];
        res.bad_request = bad;
        return res;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one request and queue its expected result
    task automatic send_request(input logic cmd, input logic [11:0] row,
                                input logic [11:0] col, input logic [23:0] vin);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {vin, col, row};
        expected_q.push_back(map_pair(cmd, row, col, vin));
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_gap(input bit gaps);
        int g;
        g = gaps ? random_gap() : 0;
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic finish_stream();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // hold one write until accepted; the caller drops valid afterwards
    task automatic write_reg(input logic [7:0] idx, input logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_DIRECTED_MODE) dir_q = val[0];
        else if (idx == REG_SELF_LOOPS) sl_q = val[0];
        else if (idx == REG_NODE_COUNT) nodes_q = val;
    endtask

    task automatic set_mode(input logic dir, input logic sl, input logic [12:0] n);
        write_reg(REG_DIRECTED_MODE, {12'd0, dir});
        write_reg(REG_SELF_LOOPS, {12'd0, sl});
        write_reg(REG_NODE_COUNT, n);
        cfg_valid <= 1'b0;
    endtask

    // one random request, valid-looking most of the time
    task automatic random_request(input bit gaps);
        int unsigned n, r, c, total;
        n = 32'(nodes_q);
        if (n < 2) n = 2;
        if (n > NPIM_MAX_NODES) n = NPIM_MAX_NODES;
        total = !dir_q ? (sl_q ? n * (n + 1) / 2 : n * (n - 1) / 2)
                       : (sl_q ? n * n : n * (n - 1));
        if ($urandom_range(0, 9) < 8)
        begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(0, n - 1);
            if (!dir_q && c > r && $urandom_range(0, 3) != 0) c = $urandom_range(0, r);
            if ($urandom_range(0, 1))
                send_request(CMD_ENCODE, r[11:0], c[11:0], 24'($urandom()));
            else
                send_request(CMD_DECODE, 12'($urandom()), 12'($urandom()),
                             24'(($urandom_range(0, 9) == 0) ? total - 1
                                                             : $urandom_range(0, total - 1)));
        end
        else
            send_request(1'($urandom_range(0, 1)), 12'($urandom()), 12'($urandom()),
                         24'($urandom()));
        send_gap(gaps);
    endtask

    // extremes of every field in every mode
    task automatic test_directed();
        logic [1:0] m;
        for (int k = 0; k < 4; k++)
        begin
            m = 2'(k);
            set_mode(m[1], m[0], (k == 3) ? 13'd4096 : 13'd5);
            send_request(CMD_ENCODE, 12'd0, 12'd0, 24'd0);
            send_request(CMD_ENCODE, 12'd4095, 12'd4095, 24'hFFFFFF);
            send_request(CMD_ENCODE, 12'd4, 12'd3, 24'd0);
            send_request(CMD_ENCODE, 12'd1, 12'd3, 24'd0);
            send_request(CMD_DECODE, 12'hFFF, 12'hFFF, 24'd0);
            send_request(CMD_DECODE, 12'd0, 12'd0, 24'd9);
            send_request(CMD_DECODE, 12'd0, 12'd0, 24'hFFFFFF);
            finish_stream();
        end
    endtask

    // undirected decode at triangular numbers and clamped node counts
    task automatic test_corner_counts();
        set_mode(1'b0, 1'b0, 13'd0);
        for (int i = 0; i < 3; i++) send_request(CMD_DECODE, 12'd0, 12'd0, 24'(i));
        finish_stream();
        set_mode(1'b0, 1'b0, 13'h1FFF);
        send_request(CMD_DECODE, 12'd0, 12'd0, 24'd6);
        send_request(CMD_DECODE, 12'd0, 12'd0, 24'd10);
        send_request(CMD_ENCODE, 12'd4095, 12'd4094, 24'd0);
        finish_stream();
        set_mode(1'b1, 1'b1, 13'd4096);
        send_request(CMD_DECODE, 12'd0, 12'd0, 24'hFFFFFF);
        finish_stream();
    endtask

    // random requests across several configurations
    task automatic test_random();
        logic [12:0] counts[6];
        counts = '{13'd2, 13'd3, 13'd17, 13'd300, 13'd4096, 13'd1000};
        for (int p = 0; p < 8; p++)
        begin
            set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     counts[$urandom_range(0, 5)]);
            for (int i = 0; i < 120; i++) random_request(p % 3 != 0);
            finish_stream();
        end
    endtask

    // stall the output long enough to back up the input
    task automatic test_backpressure();
        set_mode(1'b1, 1'b0, 13'd64);
        hold_req++;
        for (int i = 0; i < 60; i++) random_request(1'b0);
        finish_stream();
    endtask

    // result sink with random stalls, or a long counted hold-off on request
    initial
    begin
        int stall;
        int cnt;
        int holds_done;
        m_tready   = 1'b0;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req != holds_done)
            begin
                holds_done = hold_req;
                m_tready <= 1'b0;
                cnt = 0;
                while (cnt < 80)
                begin
                    @(posedge clk);
                    cnt++;
                end
            end
            stall = random_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        pair_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: %h", m_tdata);
                fail_cnt++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (m_tdata[23:0] !== exp_r.index_out)
                begin
                    $error("index_out expected %0d got %0d", exp_r.index_out, m_tdata[23:0]);
                    fail_cnt++;
                end
                if (m_tdata[35:24] !== exp_r.row_out)
                begin
                    $error("row_out expected %0d got %0d", exp_r.row_out, m_tdata[35:24]);
                    fail_cnt++;
                end
                if (m_tdata[47:36] !== exp_r.col_out)
                begin
                    $error("col_out expected %0d got %0d", exp_r.col_out, m_tdata[47:36]);
                    fail_cnt++;
                end
                if (m_tuser !== exp_r.bad_request)
                begin
                    $error("bad_request expected %0d got %0d", exp_r.bad_request, m_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        hold_req    = 0;
        dir_q       = 1'b0;
        sl_q        = 1'b0;
        nodes_q     = 13'd4096;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset-default configuration first
        send_request(CMD_ENCODE, 12'd4095, 12'd4094, 24'd0);
        send_request(CMD_DECODE, 12'd0, 12'd0, 24'hFFFFFF);
        finish_stream();
        test_directed();
        test_corner_counts();
        test_random();
        test_backpressure();
        if (fail_cnt == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
